// ===== src/base64_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// base64_decoder_top_macros.svh
// Assertion helpers for the base64 decoder block.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_TOP_MACROS_SVH
`define BASE64_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define B64D_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define B64D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    localparam logic [5:0] MASK_HI2 = 6'h30;
    localparam logic [5:0] MASK_LO4 = 6'h0F;
    localparam logic [5:0] MASK_MID = 6'h3C;
    localparam logic [5:0] MASK_LO2 = 6'h03;

    // One decoded request for the output side: one to three results.
    typedef struct packed {
        logic [2:0][7:0] bytes;     // result bytes, entry 0 goes out first
        logic [1:0]      last_idx;  // index of the final result of this request
        logic            marker;    // bare end marker, no data byte
        logic            str_end;   // request comes from the string's last char
    } b64d_job_t;

    // Front-end state, exported for checking.
    typedef struct packed {
        logic [1:0] count;
        logic       halted;
    } b64d_status_t;

    // Returns {valid, value}; valid is low for '=' and any non-alphabet byte.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b1;
        if (c inside {[8'h41:8'h5A]}) begin
            v = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = c - 8'h61 + 8'd26;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == CHAR_PLUS) begin
            v = 8'd62;
        end else if (c == CHAR_SLASH) begin
            v = 8'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, v[5:0]};
    endfunction

endpackage

// ===== src/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the sextet group and builds output requests.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_char_byte,
    input  logic         s_last_char,
    input  logic         q_full,
    output logic         q_push,
    output b64d_job_t    q_data,
    output b64d_status_t status
);

    logic [2:0][5:0] buf_reg, buf_next;
    logic [1:0]      count_reg, count_next;
    logic            halted_reg, halted_next;
    logic [6:0]      cls;
    logic [5:0]      v;
    logic [1:0]      nb;
    logic            accept;
    logic [7:0]      b0, b1, b2;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign status  = '{count: count_reg, halted: halted_reg};

    always_comb begin
        cls         = sextet_of(s_char_byte);
        v           = cls[5:0];
        buf_next    = buf_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        nb          = 2'd0;
        if (!halted_reg) begin
            if (cls[6]) begin
                if (count_reg == 2'd3) begin
                    nb         = 2'd3;
                    count_next = 2'd0;
                end else begin
                    buf_next[count_reg] = v;
                    count_next          = count_reg + 2'd1;
                end
            end else begin
                nb          = (count_reg >= 2'd2) ? count_reg - 2'd1 : 2'd0;
                count_next  = 2'd0;
                halted_next = 1'b1;
            end
        end
        // The last character flushes whatever partial group is still held.
        if (s_last_char && count_next >= 2'd2) begin
            nb = count_next - 2'd1;
        end

        b0 = {buf_next[0], 2'((buf_next[1] & MASK_HI2) >> 4)};
        b1 = {buf_next[1][3:0] & MASK_LO4[3:0], 4'((buf_next[2] & MASK_MID) >> 2)};
        b2 = {buf_next[2][1:0] & MASK_LO2[1:0], v};

        q_data.marker   = (nb == 2'd0);
        q_data.last_idx = (nb == 2'd0) ? 2'd0 : nb - 2'd1;
        q_data.str_end  = s_last_char;
        q_data.bytes    = (nb == 2'd0) ? '0 : {b2, b1, b0};
        q_push          = accept && ((nb != 2'd0) || s_last_char);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg    <= '0;
            count_reg  <= 2'd0;
            halted_reg <= 1'b0;
        end else if (accept) begin
            if (s_last_char) begin
                buf_reg    <= '0;
                count_reg  <= 2'd0;
                halted_reg <= 1'b0;
            end else begin
                buf_reg    <= buf_next;
                count_reg  <= count_next;
                halted_reg <= halted_next;
            end
        end
    end

endmodule

// ===== src/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Small request queue between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  b64d_job_t push_data,
    output logic      full,
    input  logic      pop,
    output b64d_job_t head,
    output logic      empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64d_job_t         mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== src/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Sequences each queued request into single results on the output channel.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  b64d_job_t  head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_string_end,
    output logic       m_run_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg, end_reg, last_reg;
    logic       load, is_last;
    logic [7:0] sel_byte;

    assign load    = (!valid_reg || m_ready) && !empty;
    assign is_last = (idx_reg == head.last_idx);
    assign pop     = load && is_last;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            default: sel_byte = head.bytes[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            has_reg  <= !head.marker;
            end_reg  <= head.str_end && is_last;
            last_reg <= is_last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_has_byte   = has_reg;
    assign m_string_end = end_reg;
    assign m_run_last   = last_reg;

endmodule

// ===== src/base64_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_decoder_top
// Streaming base64 decoder: characters in, decoded bytes and end markers out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid/s_ready) takes one encoded character per request,
// with s_last_char high on the final character of a string. The output channel
// (m_valid/m_ready) carries one result per request: a decoded byte with
// m_has_byte high, or a bare end marker (m_has_byte low, byte zero).
// m_run_last flags the final result caused by one character and m_string_end
// the final result of a string.
// Results pass through the request queue and then the output register. The
// front end accepts one character every cycle while the request queue has
// room; the output sequencer sends one result per cycle while the receiver is
// ready, so a character that completes a group of four holds it for its three
// bytes. With QUEUE_DEPTH requests of buffering and a ready receiver, ordinary
// text (three bytes per four characters) sustains one character per cycle.
// When the receiver stalls, the output register holds its result, the queue
// fills, and only then does s_ready drop. Reset clears the group state, the
// queue and the output valid; the block is ready once reset is released.
// ----------------------------------------------------------------------------
`include "base64_decoder_top_macros.svh"

module base64_decoder_top
    import b64d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_string_end,
    output logic       m_run_last
);

    // Requests handed from the classifier to the output sequencer.
    b64d_job_t    q_data, q_head;
    logic         q_push, q_pop, q_full, q_empty;
    b64d_status_t fe_status;

    // Front end: classifies each character and updates the group state.
    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .s_last_char (s_last_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data),
        .status      (fe_status)
    );

    // The queue lets the front keep taking characters while output stalls.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Back end: one result per cycle into the output register while the receiver is ready.
    b64d_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_string_end (m_string_end),
        .m_run_last   (m_run_last)
    );

    // A bare marker always closes both the character's run and the string.
    `B64D_ASSERT_NOW(a_marker_shape, aclk, aresetn, m_valid && !m_has_byte,
        m_string_end && m_run_last && (m_out_byte == 8'd0), "malformed end marker")

    // The end of a string is always the end of its character's run.
    `B64D_ASSERT_NOW(a_end_is_last, aclk, aresetn, m_valid && m_string_end,
        m_run_last, "string end without run end")

    // After the last character of a string the group state is clear.
    `B64D_ASSERT_NEXT(a_last_clears, aclk, aresetn, s_valid && s_ready && s_last_char,
        (fe_status.count == 2'd0) && !fe_status.halted, "state not cleared at string end")

    // A full queue must hold off the input side.
    `B64D_ASSERT_NOW(a_full_stalls, aclk, aresetn, q_full, !s_ready && !q_push,
        "request taken while queue full")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// A short table of hand-picked characters runs first. Where the decoded bytes
// are obvious they are typed into the table. Every other row, and a long run
// of random strings, is checked against a decoder model kept in this file.
// The strings are mostly well formed with padding, and some are broken or pure
// noise. The run is repeated under four mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb
    import b64d_pkg::*;
();

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       string_end;
        logic       run_last;
    } b64_result_t;

    // One row of stimulus. When typed is set, the expected results come from
    // the row itself: n bytes taken from the top of bytes, or a single bare
    // marker. Otherwise the decoder model supplies them.
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic        marker;
        logic [1:0]  n;
        logic [23:0] bytes;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int ITEMS_PER_PHASE = 85;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte = 8'h00;
    logic       s_last_char = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_string_end;
    logic       m_run_last;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // State of the decoder model.
    logic [5:0] held_sextets [0:2];
    logic [1:0] held_count = 2'd0;
    logic       decode_halted = 1'b0;

    // Results of the character just decoded, and every result still owed.
    b64_result_t step_out [$];
    b64_result_t decoded_q [$];

    int mismatch_cnt = 0;
    int checked_cnt = 0;
    int char_cnt = 0;
    int decoded_chars = 0;
    int string_cnt = 0;

    stim_row_t directed_tbl [0:DIRECTED_ROWS-1];

    base64_decoder_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_byte  (s_char_byte),
        .s_last_char  (s_last_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_has_byte   (m_has_byte),
        .m_string_end (m_string_end),
        .m_run_last   (m_run_last)
    );

    always #1 aclk = ~aclk;

    // Returns {in_alphabet, sextet}.
    function automatic logic [6:0] sextet_code(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return {1'b1, 6'(c - "A")};
        end else if (c >= "a" && c <= "z") begin
            return {1'b1, 6'(c - "a" + 26)};
        end else if (c >= "0" && c <= "9") begin
            return {1'b1, 6'(c - "0" + 52)};
        end else if (c == CHAR_PLUS) begin
            return {1'b1, 6'd62};
        end else if (c == CHAR_SLASH) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

    // Inverse of sextet_code, for building random strings.
    function automatic logic [7:0] alphabet_char(input int unsigned idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    function automatic logic [7:0] non_alphabet_char();
        logic [7:0] c;
        logic [6:0] code;
        do begin
            c = 8'($urandom_range(0, 255));
            code = sextet_code(c);
        end while (code[6]);
        return c;
    endfunction

    function automatic b64_result_t data_result(input logic [7:0] b);
        b64_result_t r;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.string_end = 1'b0;
        r.run_last = 1'b0;
        return r;
    endfunction

    // Emits the bytes that cnt held sextets (plus s3 for a full group) give.
    function automatic void emit_group(input int unsigned cnt, input logic [5:0] s3);
        if (cnt >= 2)
            step_out = {step_out, data_result({held_sextets[0], held_sextets[1][5:4]})};
        if (cnt >= 3)
            step_out = {step_out, data_result({held_sextets[1][3:0], held_sextets[2][5:2]})};
        if (cnt >= 4)
            step_out = {step_out, data_result({held_sextets[2][1:0], s3})};
    endfunction

    // Decodes one accepted character into step_out and advances the state.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        logic [6:0] code;
        b64_result_t r;
        step_out.delete();
        if (!decode_halted) begin
            code = sextet_code(c);
            if (code[6]) begin
                if (held_count == 2'd3) begin
                    emit_group(4, code[5:0]);
                    held_count = 2'd0;
                end else begin
                    held_sextets[held_count] = code[5:0];
                    held_count = held_count + 2'd1;
                end
            end else begin
                emit_group(held_count, 6'd0);
                held_count = 2'd0;
                decode_halted = 1'b1;
            end
        end
        if (last) begin
            emit_group(held_count, 6'd0);
            if (step_out.size() == 0) begin
                r = '0;
                step_out = {r};
            end
            r = step_out.pop_back();
            r.string_end = 1'b1;
            step_out = {step_out, r};
            held_sextets[0] = 6'd0;
            held_sextets[1] = 6'd0;
            held_sextets[2] = 6'd0;
            held_count = 2'd0;
            decode_halted = 1'b0;
        end
        if (step_out.size() != 0) begin
            r = step_out.pop_back();
            r.run_last = 1'b1;
            step_out = {step_out, r};
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Offers one character, waits for the request to be taken, and records
    // what it must produce. Valid is left high; the next call or the end of
    // the run decides whether it drops.
    task automatic send_char(input stim_row_t row);
        b64_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_byte <= row.ch;
        s_last_char <= row.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        char_cnt++;
        if (!decode_halted) decoded_chars++;
        if (row.last) string_cnt++;
        decode_char(row.ch, row.last);
        if (row.typed) begin
            step_out.delete();
            for (int k = 0; k < row.n; k++) begin
                if (row.marker) r = '0;
                else r = data_result(row.bytes[23 - 8 * k -: 8]);
                if (k == row.n - 1) begin
                    r.run_last = 1'b1;
                    r.string_end = row.last;
                end
                step_out = {step_out, r};
            end
        end
        foreach (step_out[k]) decoded_q = {decoded_q, step_out[k]};
    endtask

    // Sends one random string: mostly well formed with padding, some with a
    // bad character in the middle, some plain noise.
    task automatic send_random_string();
        logic [7:0] str_q [$];
        stim_row_t row;
        int unsigned kind;
        int unsigned groups;
        int unsigned rem;
        kind = $urandom_range(99);
        if (kind < 70) begin
            groups = ($urandom_range(9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
            rem = $urandom_range(0, 3);
            repeat (4 * groups + rem) str_q = {str_q, alphabet_char($urandom_range(0, 63))};
            if (rem == 2) begin
                str_q = {str_q, CHAR_PAD};
                str_q = {str_q, CHAR_PAD};
            end else if (rem == 3 || $urandom_range(1) == 0) begin
                str_q = {str_q, CHAR_PAD};
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) str_q = {str_q, 8'($urandom_range(0, 255))};
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 7)) str_q = {str_q, alphabet_char($urandom_range(0, 63))};
            str_q.insert($urandom_range(0, str_q.size()), non_alphabet_char());
            repeat ($urandom_range(0, 3)) str_q = {str_q, alphabet_char($urandom_range(0, 63))};
        end else begin
            repeat ($urandom_range(1, 6)) str_q = {str_q, 8'($urandom_range(0, 255))};
        end
        row = '0;
        foreach (str_q[i]) begin
            row.ch = str_q[i];
            row.last = (i == str_q.size() - 1);
            send_char(row);
        end
    endtask

    // Receiver: random stalls, and every taken result is compared field by
    // field with the oldest one owed.
    always @(posedge aclk) begin : result_check
        b64_result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            checked_cnt++;
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte=%02h has=%b end=%b rl=%b",
                                          m_out_byte, m_has_byte, m_string_end, m_run_last));
            end else begin
                want = decoded_q.pop_front();
                if (m_out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_out_byte, want.out_byte));
                if (m_has_byte !== want.has_byte)
                    report_mismatch($sformatf("has_byte %b, want %b",
                                              m_has_byte, want.has_byte));
                if (m_string_end !== want.string_end)
                    report_mismatch($sformatf("string_end %b, want %b",
                                              m_string_end, want.string_end));
                if (m_run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b",
                                              m_run_last, want.run_last));
            end
        end
    end

    // Safety net in case the block hangs.
    initial begin
        #400000;
        $display("[base64_decoder_top] ERROR");
        $finish;
    end

    initial begin
        // ch, last, typed, marker, n, bytes
        directed_tbl = '{
            '{CHAR_PAD,   1'b1, 1'b1, 1'b1, 2'd1, 24'h0},      // pad alone ends the string
            '{"A",        1'b1, 1'b1, 1'b1, 2'd1, 24'h0},      // single sextet gives nothing
            '{CHAR_SLASH, 1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{CHAR_SLASH, 1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{CHAR_SLASH, 1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{CHAR_SLASH, 1'b0, 1'b1, 1'b0, 2'd3, 24'hFFFFFF}, // all-ones group
            '{CHAR_PLUS,  1'b0, 1'b0, 1'b0, 2'd0, 24'h0},
            '{"z",        1'b0, 1'b0, 1'b0, 2'd0, 24'h0},
            '{"9",        1'b0, 1'b0, 1'b0, 2'd0, 24'h0},
            '{CHAR_PAD,   1'b0, 1'b0, 1'b0, 2'd0, 24'h0},      // flush of three sextets
            '{8'h80,      1'b0, 1'b1, 1'b0, 2'd0, 24'h0},      // ignored after the halt
            '{"Q",        1'b1, 1'b1, 1'b1, 2'd1, 24'h0},      // halted last char: marker
            '{"A",        1'b0, 1'b0, 1'b0, 2'd0, 24'h0},
            '{"Z",        1'b0, 1'b0, 1'b0, 2'd0, 24'h0},
            '{"a",        1'b1, 1'b0, 1'b0, 2'd0, 24'h0},      // partial group on last char
            '{"T",        1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{"W",        1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{"F",        1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{"u",        1'b1, 1'b1, 1'b0, 2'd3, 24'h4D616E}, // group completed by last char
            '{8'hFF,      1'b1, 1'b1, 1'b1, 2'd1, 24'h0},      // bad byte as whole string
            '{8'h00,      1'b0, 1'b1, 1'b0, 2'd0, 24'h0},      // bad byte with nothing held
            '{"0",        1'b1, 1'b1, 1'b1, 2'd1, 24'h0},
            '{"A",        1'b0, 1'b1, 1'b0, 2'd0, 24'h0},
            '{CHAR_PAD,   1'b1, 1'b1, 1'b1, 2'd1, 24'h0}       // pad after one sextet
        };
        held_sextets[0] = 6'd0;
        held_sextets[1] = 6'd0;
        held_sextets[2] = 6'd0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows run with no gaps and no stalls.
        for (int i = 0; i < DIRECTED_ROWS; i++) send_char(directed_tbl[i]);

        // Random strings under four handshake mixes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase
            while (char_cnt < DIRECTED_ROWS + ITEMS_PER_PHASE * (ph + 1))
                send_random_string();
        end

        // Stop sending at the edge that took the last character, then let
        // every owed result come out.
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d characters in %0d strings (%0d decoded), checked %0d results.",
                 char_cnt, string_cnt, decoded_chars, checked_cnt);
        $display("Mixes covered: free flow, sparse sender, stalled receiver, both throttled.");
        if (mismatch_cnt == 0) begin
            $display("[base64_decoder_top] OK");
        end else begin
            $display("[base64_decoder_top] ERROR");
        end
        $finish;
    end

endmodule
